// ----- sv/fela_pkg.sv -----
// ----------------------------------------------------------------------------
// fela_pkg: shared types and constants
// Request codes, arithmetic-unit opcodes, the pipeline item record and the
// single-precision constants used by the approximate exp/log pipeline.
// ----------------------------------------------------------------------------
package fela_pkg;

  // Request codes carried on req_type.
  typedef enum logic [1:0] {
    REQ_EXP2 = 2'd0,
    REQ_LOG2 = 2'd1,
    REQ_EXP  = 2'd2,
    REQ_LN   = 2'd3
  } req_t;

  // Operation of one arithmetic slot.
  typedef enum logic [1:0] {
    FOP_PASS = 2'd0,
    FOP_ADD  = 2'd1,
    FOP_MUL  = 2'd2
  } fop_t;

  // One item as it travels down the pipeline.
  typedef struct packed {
    logic        v;
    req_t        req;
    logic        err;
    logic        spec;
    logic [31:0] acc;
    logic [31:0] aux;
    logic [31:0] hold;
  } item_t;

  localparam int unsigned NUM_STAGES = 9;

  // Special bit patterns.
  localparam logic [31:0] F_QNAN = 32'h7fc0_0000;
  localparam logic [31:0] F_PINF = 32'h7f80_0000;
  localparam logic [31:0] F_NINF = 32'hff80_0000;

  // Single-precision constants.
  localparam logic [31:0] F_ONE       = 32'h3f80_0000;
  localparam logic [31:0] F_TWO       = 32'h4000_0000;
  localparam logic [31:0] F_127       = 32'h42fe_0000;
  localparam logic [31:0] F_255       = 32'h437f_0000;
  localparam logic [31:0] F_NEG128    = 32'hc300_0000;
  localparam logic [31:0] F_C1        = 32'h3ead_f5d0;  // 0.339766027
  localparam logic [31:0] F_C2        = 32'h3f29_0518;  // 0.660233972
  localparam logic [31:0] F_NEG_THIRD = 32'hbeaa_aaab;  // -0.333333333
  localparam logic [31:0] F_NEG_C23   = 32'hbf2a_aaab;  // -0.666666666
  localparam logic [31:0] F_LOG2E     = 32'h3fb8_aa3b;
  localparam logic [31:0] F_LN2       = 32'h3f31_7218;

  // Exact conversion of a small signed magnitude to single precision.
  function automatic logic [31:0] int_to_f(input logic neg, input logic [7:0] mag);
    logic [2:0]  p;
    logic [23:0] m24;
    logic [7:0]  ex;
    p = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) begin
        p = 3'(i);
      end
    end
    m24 = 24'(mag) << (5'd23 - 5'(p));
    ex  = 8'd127 + 8'(p);
    if (mag == 8'd0) begin
      int_to_f = 32'h0;
    end else begin
      int_to_f = {neg, ex, m24[22:0]};
    end
  endfunction

endpackage

// ----- sv/fela_fpu.sv -----
// ----------------------------------------------------------------------------
// fela_fpu: single-precision add / multiply slot
// Combinational IEEE single add or multiply with round to nearest even and
// full subnormal support, or a plain pass of operand a.
// ----------------------------------------------------------------------------
module fela_fpu (
  input  fela_pkg::fop_t op,
  input  logic [31:0]    a,
  input  logic [31:0]    b,
  output logic [31:0]    y
);
  import fela_pkg::*;

  // Leading-zero count by halving steps.
  function automatic logic [5:0] lzc64(input logic [63:0] v);
    logic [63:0] x;
    logic [5:0]  n;
    x = v;
    n = 6'd0;
    if (x[63:32] == 32'd0) begin n[5] = 1'b1; x = x << 32; end
    if (x[63:48] == 16'd0) begin n[4] = 1'b1; x = x << 16; end
    if (x[63:56] == 8'd0)  begin n[3] = 1'b1; x = x << 8;  end
    if (x[63:60] == 4'd0)  begin n[2] = 1'b1; x = x << 4;  end
    if (x[63:62] == 2'd0)  begin n[1] = 1'b1; x = x << 2;  end
    if (x[63] == 1'b0)     begin n[0] = 1'b1; end
    lzc64 = n;
  endfunction

  // Round and pack a significand whose leading one sits at bit 47.
  function automatic logic [31:0] fp_round(input logic sign, input logic signed [11:0] re,
                                           input logic [47:0] sig);
    logic [5:0]  sh;
    logic [47:0] s2;
    logic        st_lo;
    logic [22:0] man;
    logic [7:0]  ex;
    logic        g;
    logic        st;
    logic        inc;
    logic [30:0] mag;
    sh = 6'd0;
    if (re >= 12'sd1) begin
      s2    = sig;
      st_lo = 1'b0;
      ex    = re[7:0];
    end else begin
      sh    = (re < -12'sd46) ? 6'd48 : 6'(12'sd1 - re);
      s2    = sig >> sh;
      st_lo = |(sig & ~({48{1'b1}} << sh));
      ex    = 8'd0;
    end
    man = s2[46:24];
    g   = s2[23];
    st  = (|s2[22:0]) | st_lo;
    inc = g & (st | man[0]);
    mag = {ex, man} + 31'(inc);
    if (sig == 48'd0) begin
      fp_round = {sign, 31'd0};
    end else if (re >= 12'sd255) begin
      fp_round = {sign, 8'hff, 23'd0};
    end else begin
      fp_round = {sign, mag};
    end
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] x, input logic [31:0] z);
    logic        s;
    logic        x_nan, z_nan, x_inf, z_inf, x_zero, z_zero;
    logic [23:0] mx, mz;
    logic [8:0]  ex, ez;
    logic [47:0] p;
    logic [5:0]  lz;
    logic [47:0] pn;
    logic signed [11:0] re;
    s      = x[31] ^ z[31];
    x_nan  = (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
    z_nan  = (z[30:23] == 8'hff) && (z[22:0] != 23'd0);
    x_inf  = (x[30:0] == F_PINF[30:0]);
    z_inf  = (z[30:0] == F_PINF[30:0]);
    x_zero = (x[30:0] == 31'd0);
    z_zero = (z[30:0] == 31'd0);
    mx = {x[30:23] != 8'd0, x[22:0]};
    mz = {z[30:23] != 8'd0, z[22:0]};
    ex = (x[30:23] == 8'd0) ? 9'd1 : {1'b0, x[30:23]};
    ez = (z[30:23] == 8'd0) ? 9'd1 : {1'b0, z[30:23]};
    p  = mx * mz;
    lz = lzc64({p, 16'd0});
    pn = p << lz;
    re = $signed(12'(ex) + 12'(ez) - 12'd126 - 12'(lz));
    if (x_nan || z_nan || (x_inf && z_zero) || (z_inf && x_zero)) begin
      fp_mul = F_QNAN;
    end else if (x_inf || z_inf) begin
      fp_mul = {s, F_PINF[30:0]};
    end else begin
      fp_mul = fp_round(s, re, pn);
    end
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] x0, input logic [31:0] z0);
    logic [31:0] x, z;
    logic        x_nan, z_nan, x_inf, z_inf;
    logic [7:0]  ex, ez, d;
    logic [5:0]  dd;
    logic [49:0] xa, z_full, za, s50, sn;
    logic        sticky;
    logic [5:0]  lz;
    logic [47:0] sig;
    logic signed [11:0] re;
    x_nan = (x0[30:23] == 8'hff) && (x0[22:0] != 23'd0);
    z_nan = (z0[30:23] == 8'hff) && (z0[22:0] != 23'd0);
    x_inf = (x0[30:0] == F_PINF[30:0]);
    z_inf = (z0[30:0] == F_PINF[30:0]);
    // Larger magnitude first.
    if (x0[30:0] < z0[30:0]) begin
      x = z0;
      z = x0;
    end else begin
      x = x0;
      z = z0;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ez = (z[30:23] == 8'd0) ? 8'd1 : z[30:23];
    d  = ex - ez;
    dd = (d > 8'd49) ? 6'd50 : d[5:0];
    xa     = {1'b0, x[30:23] != 8'd0, x[22:0], 25'd0};
    z_full = {1'b0, z[30:23] != 8'd0, z[22:0], 25'd0};
    za     = z_full >> dd;
    sticky = |(z_full & ~({50{1'b1}} << dd));
    za[0]  = za[0] | sticky;
    s50 = (x[31] ^ z[31]) ? (xa - za) : (xa + za);
    lz  = lzc64({s50, 14'd0});
    sn  = s50 << lz;
    sig = {sn[49:3], |sn[2:0]};
    re  = $signed(12'(ex) + 12'd1 - 12'(lz));
    if (x_nan || z_nan || (x_inf && z_inf && (x0[31] != z0[31]))) begin
      fp_add = F_QNAN;
    end else if (x_inf) begin
      fp_add = x0;
    end else if (z_inf) begin
      fp_add = z0;
    end else if (s50 == 50'd0) begin
      fp_add = {x0[31] & z0[31], 31'd0};
    end else begin
      fp_add = fp_round(x[31], re, sig);
    end
  endfunction

  // Operation select.
  always_comb begin
    unique case (op)
      FOP_ADD: y = fp_add(a, b);
      FOP_MUL: y = fp_mul(a, b);
      default: y = a;
    endcase
  end

endmodule

// ----- sv/fast_exp_log_approx_f32_top.sv -----
// ----------------------------------------------------------------------------
// fast_exp_log_approx_f32_top: approximate exp2 / log2 / exp / ln
// Nine-stage single-precision pipeline; each stage holds one add or
// multiply slot, and out-of-domain operands ride along as flagged results.
// ----------------------------------------------------------------------------
//  Channel   Signals                                 Direction  Transfer
//  request   start, busy, req_type, operand_bits     in         start & !busy
//  result    done, result_bits, range_error          out        done (one cycle)
//
//  One request is taken every cycle; busy stays low.
//  Each result leaves the last stage register, one add or multiply
//  per stage, in request order.
//  Reset (rst, synchronous) empties the pipeline; no result is lost to a
//  stall since the receiver always takes the result in its strobe cycle.
// ----------------------------------------------------------------------------
module fast_exp_log_approx_f32_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [31:0] operand_bits,
  output logic        done,
  output logic [31:0] result_bits,
  output logic        range_error
);
  import fela_pkg::*;

  typedef struct packed {
    fop_t        op;
    logic [31:0] a;
    logic [31:0] b;
  } slot_sel_t;

  item_t in0;
  item_t stg [1:NUM_STAGES];
  item_t nxt [1:NUM_STAGES];

  function automatic logic is_exp(input item_t it);
    is_exp = (it.req == REQ_EXP2) || (it.req == REQ_EXP);
  endfunction

  // Operand routing of each stage's slot.
  function automatic slot_sel_t stage_sel(input int unsigned idx, input item_t it);
    slot_sel_t s;
    s.op = FOP_PASS;
    s.a  = it.acc;
    s.b  = 32'd0;
    if (!it.spec) begin
      unique case (idx)
        1: begin
          if (it.req == REQ_EXP) begin
            s = slot_sel_t'{FOP_MUL, it.acc, F_LOG2E};
          end else if (!is_exp(it)) begin
            s = slot_sel_t'{FOP_MUL, it.aux, F_NEG_THIRD};
          end
        end
        2: s = slot_sel_t'{FOP_ADD, it.acc, is_exp(it) ? F_127 : F_TWO};
        3: begin
          if (!is_exp(it)) begin
            s = slot_sel_t'{FOP_MUL, it.aux, it.acc};
          end
        end
        4: s = is_exp(it) ? slot_sel_t'{FOP_ADD, it.aux, it.acc}
                          : slot_sel_t'{FOP_ADD, it.acc, F_NEG128};
        5: s = is_exp(it) ? slot_sel_t'{FOP_MUL, it.acc, F_C1}
                          : slot_sel_t'{FOP_ADD, it.acc, F_NEG_C23};
        6: s = is_exp(it) ? slot_sel_t'{FOP_ADD, it.acc, F_C2}
                          : slot_sel_t'{FOP_ADD, it.hold, it.acc};
        7: begin
          if (is_exp(it)) begin
            s = slot_sel_t'{FOP_MUL, it.aux, it.acc};
          end else if (it.req == REQ_LN) begin
            s = slot_sel_t'{FOP_MUL, it.acc, F_LN2};
          end
        end
        8: begin
          if (is_exp(it)) begin
            s = slot_sel_t'{FOP_ADD, it.acc, F_ONE};
          end
        end
        9: begin
          if (is_exp(it)) begin
            s = slot_sel_t'{FOP_MUL, it.acc, it.hold};
          end
        end
        default: ;
      endcase
    end
    stage_sel = s;
  endfunction

  // Next item of a stage; the exp range check and split sit in stage three.
  function automatic item_t stage_next(input int unsigned idx, input item_t it,
                                       input logic [31:0] y);
    item_t       n;
    logic [31:0] t;
    logic [2:0]  sh;
    logic [7:0]  e;
    logic        neg;
    logic [7:0]  mag;
    n     = it;
    n.acc = y;
    t     = it.acc;
    sh    = 3'(t[30:23] - 8'd127);
    e     = 8'({1'b1, t[22:16]} >> (3'd7 - sh));
    neg   = (e > 8'd127);
    mag   = neg ? (e - 8'd127) : (8'd127 - e);
    if (!it.spec && is_exp(it)) begin
      if (idx == 2) begin
        n.aux = it.acc;
      end
      if (idx == 4) begin
        n.aux = y;
      end
      if (idx == 3) begin
        if (t[31] || (t[30:0] < F_ONE[30:0])) begin
          n.spec = 1'b1;
          n.err  = 1'b1;
          n.acc  = 32'd0;
        end else if (t[30:0] >= F_255[30:0]) begin
          n.spec = 1'b1;
          n.err  = 1'b1;
          n.acc  = F_PINF;
        end else begin
          n.acc  = int_to_f(neg, mag);
          n.hold = {1'b0, e, 23'd0};
        end
      end
    end
    stage_next = n;
  endfunction

  // Request decode and input-side special cases.
  always_comb begin
    in0.v    = start;
    in0.req  = req_t'(req_type);
    in0.err  = 1'b0;
    in0.spec = 1'b0;
    in0.acc  = operand_bits;
    in0.aux  = {9'h07f, operand_bits[22:0]};
    in0.hold = int_to_f(1'b0, operand_bits[30:23]);
    if ((operand_bits[30:23] == 8'hff) && (operand_bits[22:0] != 23'd0)) begin
      in0.spec = 1'b1;
      in0.err  = 1'b1;
      in0.acc  = F_QNAN;
    end else if ((in0.req == REQ_LOG2) || (in0.req == REQ_LN)) begin
      if (operand_bits[30:0] == 31'd0) begin
        in0.spec = 1'b1;
        in0.err  = 1'b1;
        in0.acc  = F_NINF;
      end else if (operand_bits[31]) begin
        in0.spec = 1'b1;
        in0.err  = 1'b1;
        in0.acc  = F_QNAN;
      end else if (operand_bits == F_PINF) begin
        in0.spec = 1'b1;
        in0.err  = 1'b1;
        in0.acc  = F_PINF;
      end
    end
  end

  // One arithmetic slot per stage.
  for (genvar g = 1; g <= NUM_STAGES; g++) begin : g_stage
    item_t       src;
    slot_sel_t   sel;
    logic [31:0] y;

    if (g == 1) begin : g_first
      assign src = in0;
    end else begin : g_rest
      assign src = stg[g-1];
    end

    assign sel = stage_sel(g, src);

    fela_fpu u_fpu (
      .op (sel.op),
      .a  (sel.a),
      .b  (sel.b),
      .y  (y)
    );

    assign nxt[g] = stage_next(g, src, y);
  end

  // Stage registers; reset clears only the valid bits.
  always_ff @(posedge clk) begin
    for (int i = 1; i <= NUM_STAGES; i++) begin
      stg[i] <= {nxt[i].v & ~rst, nxt[i][$bits(item_t)-2:0]};
    end
  end

  // Result port.
  assign busy        = 1'b0;
  assign done        = stg[NUM_STAGES].v;
  assign result_bits = stg[NUM_STAGES].acc;
  assign range_error = stg[NUM_STAGES].err;

endmodule
